// ===== hw/rtl/fclp_pkg.sv =====
// Package for the fan command line parser: result codes, character
// constants and keyword lookup functions. No dependencies.
package fclp_pkg;

    typedef enum logic [3:0] {
        RES_START      = 4'd0,
        RES_STOP       = 4'd1,
        RES_ZERO_DUTY  = 4'd2,
        RES_STATUS     = 4'd3,
        RES_HELP       = 4'd4,
        RES_SET_DUTY   = 4'd5,
        RES_SET_PPR    = 4'd6,
        RES_TOO_LONG   = 4'd7,
        RES_BAD_NUMBER = 4'd8,
        RES_UNKNOWN    = 4'd9
    } result_code_t;

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [6:0] DUTY_MAX  = 7'd100;
    localparam logic [8:0] PPR_SAT   = 9'd256;
    localparam logic [7:0] PPR_MAX   = 8'd255;
    localparam logic [7:0] PPR_MIN   = 8'd1;
    localparam logic [7:0] PPR_RESET = 8'd2;

    localparam logic [8:0] DUTY_MIN_LEN = 9'd2;
    localparam logic [8:0] PPR_MIN_LEN  = 9'd4;
    localparam logic [8:0] TOO_LONG_LEN = 9'd9;
    localparam logic [8:0] PPR_PREFIX_LEN = 9'd3;

    localparam int KW_COUNT = 4;
    localparam logic [1:0] KW_START  = 2'd0;
    localparam logic [1:0] KW_STOP   = 2'd1;
    localparam logic [1:0] KW_STATUS = 2'd2;
    localparam logic [1:0] KW_HELP   = 2'd3;

    function automatic logic letter_eq(input logic [7:0] b, input logic [7:0] upper);
        return (b == upper) || (b == upper + CASE_OFFSET);
    endfunction

    function automatic logic [8:0] kw_len(input logic [1:0] k);
        logic [8:0] len;
        case (k)
            KW_START:  len = 9'd5;
            KW_STOP:   len = 9'd4;
            KW_STATUS: len = 9'd6;
            KW_HELP:   len = 9'd4;
            default:   len = 9'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            KW_START: begin
                case (p)
                    3'd0: c = "S";
                    3'd1: c = "T";
                    3'd2: c = "A";
                    3'd3: c = "R";
                    3'd4: c = "T";
                    default: c = 8'h00;
                endcase
            end
            KW_STOP: begin
                case (p)
                    3'd0: c = "S";
                    3'd1: c = "T";
                    3'd2: c = "O";
                    3'd3: c = "P";
                    default: c = 8'h00;
                endcase
            end
            KW_STATUS: begin
                case (p)
                    3'd0: c = "S";
                    3'd1: c = "T";
                    3'd2: c = "A";
                    3'd3: c = "T";
                    3'd4: c = "U";
                    3'd5: c = "S";
                    default: c = 8'h00;
                endcase
            end
            KW_HELP: begin
                case (p)
                    3'd0: c = "H";
                    3'd1: c = "E";
                    3'd2: c = "L";
                    3'd3: c = "P";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ppr_char(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = "P";
            2'd1:    c = "P";
            2'd2:    c = "R";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/fan_command_line_parser_core.sv =====
// An accepted byte is held in the input register and parsed from there; a line's
// result is registered in the output register once its terminator is parsed.
// Throughput: one byte per cycle; only a stalled result holding the output
// register while another line ends slows the input.
// Reset (aresetn low, synchronous): clears the line state, sets pulses per
// revolution to 2 and empties the input and result registers.
module fan_command_line_parser_core #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_result_code,
    output logic [7:0] m_value,
    output logic [7:0] m_pulses_per_rev_now
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(LINE_CAPACITY - 1);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    logic [LEN_W-1:0] line_length_reg, line_length_next;
    logic [3:0]       kw_flags_reg, kw_flags_next;
    logic             first_is_s_reg, first_is_s_next;
    logic             ppr_prefix_ok_reg, ppr_prefix_ok_next;
    logic             duty_digits_ok_reg, duty_digits_ok_next;
    logic             ppr_digits_ok_reg, ppr_digits_ok_next;
    logic [6:0]       duty_acc_reg, duty_acc_next;
    logic [8:0]       ppr_acc_reg, ppr_acc_next;
    logic [7:0]       ppr_reg, ppr_next;

    logic                  out_valid_reg, out_valid_next;
    fclp_pkg::result_code_t out_code_reg, out_code_next;
    logic [7:0]            out_value_reg, out_value_next;
    logic [7:0]            out_ppr_reg, out_ppr_next;

    logic        is_term;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic        emit;
    logic        advance;
    logic [8:0]  len_wide;
    logic [9:0]  duty_prod;
    logic [11:0] ppr_prod;
    logic [7:0]  ppr_clamped;

    assign is_term   = (in_byte_reg == fclp_pkg::CHAR_LF) || (in_byte_reg == fclp_pkg::CHAR_CR);
    assign is_digit  = (in_byte_reg >= fclp_pkg::CHAR_ZERO) && (in_byte_reg <= fclp_pkg::CHAR_NINE);
    assign digit_val = in_byte_reg[3:0];
    assign len_wide  = 9'(line_length_reg);
    assign emit      = in_valid_reg && is_term && (line_length_reg != '0);
    assign advance   = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    assign duty_prod = (10'(duty_acc_reg) << 3) + (10'(duty_acc_reg) << 1) + 10'(digit_val);
    assign ppr_prod  = (12'(ppr_acc_reg) << 3) + (12'(ppr_acc_reg) << 1) + 12'(digit_val);

    always_comb begin
        if (ppr_acc_reg == 9'd0) begin
            ppr_clamped = fclp_pkg::PPR_MIN;
        end else if (ppr_acc_reg > 9'(fclp_pkg::PPR_MAX)) begin
            ppr_clamped = fclp_pkg::PPR_MAX;
        end else begin
            ppr_clamped = ppr_acc_reg[7:0];
        end
    end

    always_comb begin
        in_valid_next       = in_valid_reg;
        line_length_next    = line_length_reg;
        kw_flags_next       = kw_flags_reg;
        first_is_s_next     = first_is_s_reg;
        ppr_prefix_ok_next  = ppr_prefix_ok_reg;
        duty_digits_ok_next = duty_digits_ok_reg;
        ppr_digits_ok_next  = ppr_digits_ok_reg;
        duty_acc_next       = duty_acc_reg;
        ppr_acc_next        = ppr_acc_reg;
        ppr_next            = ppr_reg;
        out_valid_next      = out_valid_reg && !m_ready;
        out_code_next       = out_code_reg;
        out_value_next      = out_value_reg;
        out_ppr_next        = out_ppr_reg;

        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        if (advance) begin
            if (is_term) begin
                if (emit) begin
                    // resolve the finished line
                    out_valid_next = 1'b1;
                    out_value_next = 8'd0;
                    out_ppr_next   = ppr_reg;
                    if (kw_flags_reg[fclp_pkg::KW_START] &&
                        len_wide == fclp_pkg::kw_len(fclp_pkg::KW_START)) begin
                        out_code_next = fclp_pkg::RES_START;
                    end else if (kw_flags_reg[fclp_pkg::KW_STOP] &&
                                 len_wide == fclp_pkg::kw_len(fclp_pkg::KW_STOP)) begin
                        out_code_next = fclp_pkg::RES_STOP;
                    end else if (kw_flags_reg[fclp_pkg::KW_STATUS] &&
                                 len_wide == fclp_pkg::kw_len(fclp_pkg::KW_STATUS)) begin
                        out_code_next = fclp_pkg::RES_STATUS;
                    end else if (kw_flags_reg[fclp_pkg::KW_HELP] &&
                                 len_wide == fclp_pkg::kw_len(fclp_pkg::KW_HELP)) begin
                        out_code_next = fclp_pkg::RES_HELP;
                    end else if (len_wide >= fclp_pkg::DUTY_MIN_LEN && first_is_s_reg) begin
                        if (len_wide >= fclp_pkg::TOO_LONG_LEN) begin
                            out_code_next = fclp_pkg::RES_TOO_LONG;
                        end else if (!duty_digits_ok_reg) begin
                            out_code_next = fclp_pkg::RES_BAD_NUMBER;
                        end else if (duty_acc_reg == 7'd0) begin
                            out_code_next = fclp_pkg::RES_ZERO_DUTY;
                        end else begin
                            out_code_next  = fclp_pkg::RES_SET_DUTY;
                            out_value_next = 8'(duty_acc_reg);
                        end
                    end else if (len_wide >= fclp_pkg::PPR_MIN_LEN && ppr_prefix_ok_reg) begin
                        if (len_wide >= fclp_pkg::TOO_LONG_LEN) begin
                            out_code_next = fclp_pkg::RES_TOO_LONG;
                        end else if (!ppr_digits_ok_reg) begin
                            out_code_next = fclp_pkg::RES_BAD_NUMBER;
                        end else begin
                            out_code_next  = fclp_pkg::RES_SET_PPR;
                            out_value_next = ppr_clamped;
                            out_ppr_next   = ppr_clamped;
                            ppr_next       = ppr_clamped;
                        end
                    end else begin
                        out_code_next = fclp_pkg::RES_UNKNOWN;
                    end
                    line_length_next    = '0;
                    kw_flags_next       = 4'hF;
                    first_is_s_next     = 1'b0;
                    ppr_prefix_ok_next  = 1'b1;
                    duty_digits_ok_next = 1'b1;
                    ppr_digits_ok_next  = 1'b1;
                    duty_acc_next       = 7'd0;
                    ppr_acc_next        = 9'd0;
                end
            end else if (line_length_reg == LAST_POS) begin
                // drop the overflowing line
                line_length_next    = '0;
                kw_flags_next       = 4'hF;
                first_is_s_next     = 1'b0;
                ppr_prefix_ok_next  = 1'b1;
                duty_digits_ok_next = 1'b1;
                ppr_digits_ok_next  = 1'b1;
                duty_acc_next       = 7'd0;
                ppr_acc_next        = 9'd0;
            end else begin
                for (int k = 0; k < fclp_pkg::KW_COUNT; k++) begin
                    if (len_wide >= fclp_pkg::kw_len(2'(k)) ||
                        !fclp_pkg::letter_eq(in_byte_reg,
                                             fclp_pkg::kw_char(2'(k), len_wide[2:0]))) begin
                        kw_flags_next[k] = 1'b0;
                    end
                end
                if (line_length_reg == '0) begin
                    first_is_s_next = fclp_pkg::letter_eq(in_byte_reg, fclp_pkg::CHAR_S);
                end
                if (len_wide < fclp_pkg::PPR_PREFIX_LEN &&
                    !fclp_pkg::letter_eq(in_byte_reg, fclp_pkg::ppr_char(len_wide[1:0]))) begin
                    ppr_prefix_ok_next = 1'b0;
                end
                if (line_length_reg != '0) begin
                    if (is_digit) begin
                        duty_acc_next = (duty_prod > 10'(fclp_pkg::DUTY_MAX)) ?
                                        fclp_pkg::DUTY_MAX : duty_prod[6:0];
                    end else begin
                        duty_digits_ok_next = 1'b0;
                    end
                end
                if (len_wide >= fclp_pkg::PPR_PREFIX_LEN) begin
                    if (is_digit) begin
                        ppr_acc_next = (ppr_prod > 12'(fclp_pkg::PPR_SAT)) ?
                                       fclp_pkg::PPR_SAT : ppr_prod[8:0];
                    end else begin
                        ppr_digits_ok_next = 1'b0;
                    end
                end
                line_length_next = line_length_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            line_length_reg    <= '0;
            kw_flags_reg       <= 4'hF;
            first_is_s_reg     <= 1'b0;
            ppr_prefix_ok_reg  <= 1'b1;
            duty_digits_ok_reg <= 1'b1;
            ppr_digits_ok_reg  <= 1'b1;
            duty_acc_reg       <= 7'd0;
            ppr_acc_reg        <= 9'd0;
            ppr_reg            <= fclp_pkg::PPR_RESET;
            out_valid_reg      <= 1'b0;
        end else begin
            in_valid_reg       <= in_valid_next;
            line_length_reg    <= line_length_next;
            kw_flags_reg       <= kw_flags_next;
            first_is_s_reg     <= first_is_s_next;
            ppr_prefix_ok_reg  <= ppr_prefix_ok_next;
            duty_digits_ok_reg <= duty_digits_ok_next;
            ppr_digits_ok_reg  <= ppr_digits_ok_next;
            duty_acc_reg       <= duty_acc_next;
            ppr_acc_reg        <= ppr_acc_next;
            ppr_reg            <= ppr_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        out_code_reg  <= out_code_next;
        out_value_reg <= out_value_next;
        out_ppr_reg   <= out_ppr_next;
    end

    assign m_valid              = out_valid_reg;
    assign m_result_code        = out_code_reg;
    assign m_value              = out_value_reg;
    assign m_pulses_per_rev_now = out_ppr_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        ppr_reg != 8'd0)
        else $error("pulses per revolution reached zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code == fclp_pkg::RES_SET_PPR) |-> m_value == m_pulses_per_rev_now)
        else $error("set ppr result disagrees with held ppr");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code != fclp_pkg::RES_SET_PPR) &&
        (m_result_code != fclp_pkg::RES_SET_DUTY) |-> m_value == 8'd0)
        else $error("nonzero value on a result without a value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code == fclp_pkg::RES_SET_DUTY) |->
        (m_value != 8'd0) && (m_value <= 8'(fclp_pkg::DUTY_MAX)))
        else $error("duty value out of range");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");
`endif

endmodule
